### src/ffd_pkg.sv
// Shared types, constants and the soft-clip table builder for the filtered feedback delay.
package ffd_pkg;

  // Sample and arithmetic widths
  localparam int SAMPLE_BITS = 24;
  localparam int SHIFT       = 32 - SAMPLE_BITS;
  localparam int OUT_K       = 16 + SHIFT;
  localparam int ACC_W       = 51;
  localparam int MA_W        = 33;
  localparam int MB_W        = 26;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int MAG_W       = 37;

  // Soft-clip table geometry
  localparam int CLIP_TABLE_SIZE = 1024;
  localparam int CLIP_LOG        = $clog2(CLIP_TABLE_SIZE);
  localparam int CLIP_SHIFT      = 33 - CLIP_LOG;
  localparam int FR_W            = 25;
  localparam int FR_PAD          = CLIP_LOG - 8;
  localparam int CLIP_AW         = $clog2(CLIP_TABLE_SIZE + 1);

  // Configuration register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_DELAY  = 3'd0;
  localparam logic [2:0] REG_FB     = 3'd1;
  localparam logic [2:0] REG_MIX    = 3'd2;
  localparam logic [2:0] REG_LP     = 3'd3;
  localparam logic [2:0] REG_HP     = 3'd4;
  localparam logic [2:0] REG_RGAIN  = 3'd5;
  localparam logic [2:0] REG_RES_ON = 3'd6;

  localparam logic [16:0] RST_DELAY  = 17'd22050;
  localparam logic [15:0] RST_FB     = 16'd39322;
  localparam logic [16:0] RST_MIX    = 17'd32768;
  localparam logic [15:0] RST_LP     = 16'd19386;
  localparam logic [15:0] RST_HP     = 16'd61768;
  localparam logic [16:0] RST_RGAIN  = 17'd31130;
  localparam logic        RST_RES_ON = 1'b1;

  typedef struct packed {
    logic [16:0] delay_length;
    logic [15:0] feedback_gain;
    logic [16:0] wet_mix;
    logic [15:0] lowpass_pole;
    logic [15:0] highpass_pole;
    logic [16:0] resonance_gain;
    logic        resonance_on;
  } cfg_t;

  // Multiplier operand pairs
  typedef logic [3:0] mul_sel_t;
  localparam mul_sel_t MUL_NONE    = 4'd0;
  localparam mul_sel_t MUL_A_LP    = 4'd1;
  localparam mul_sel_t MUL_NA_D    = 4'd2;
  localparam mul_sel_t MUL_B_HP    = 4'd3;
  localparam mul_sel_t MUL_NB_LP   = 4'd4;
  localparam mul_sel_t MUL_F_RG    = 4'd5;
  localparam mul_sel_t MUL_DIFF_FR = 4'd6;
  localparam mul_sel_t MUL_F_FG    = 4'd7;
  localparam mul_sel_t MUL_F_M     = 4'd8;
  localparam mul_sel_t MUL_X_NM    = 4'd9;

  // Accumulator operations
  typedef logic [2:0] acc_sel_t;
  localparam acc_sel_t ACC_HOLD    = 3'd0;
  localparam acc_sel_t ACC_ADD     = 3'd1;
  localparam acc_sel_t ACC_LD_POLE = 3'd2;
  localparam acc_sel_t ACC_LD_CLIP = 3'd3;
  localparam acc_sel_t ACC_LD_X    = 3'd4;
  localparam acc_sel_t ACC_LD_OUT  = 3'd5;

  // Register load operations
  typedef logic [3:0] op_sel_t;
  localparam op_sel_t OP_NONE  = 4'd0;
  localparam op_sel_t OP_LP    = 4'd1;
  localparam op_sel_t OP_HP    = 4'd2;
  localparam op_sel_t OP_FSUB  = 4'd3;
  localparam op_sel_t OP_FSAT  = 4'd4;
  localparam op_sel_t OP_MAG   = 4'd5;
  localparam op_sel_t OP_ROM   = 4'd6;
  localparam op_sel_t OP_DIFF  = 4'd7;
  localparam op_sel_t OP_R     = 4'd8;
  localparam op_sel_t OP_FCLIP = 4'd9;
  localparam op_sel_t OP_WR    = 4'd10;
  localparam op_sel_t OP_OUT   = 4'd11;

  typedef struct packed {
    logic     take;
    mul_sel_t mul;
    acc_sel_t acc;
    op_sel_t  op;
  } cmd_t;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [31:0] clip_rom_t [0:CLIP_TABLE_SIZE];

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input acc_t v);
    logic signed [31:0] r;
    if (&v[ACC_W-1:31] || ~|v[ACC_W-1:31]) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  // Saturate to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input acc_t v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (&v[ACC_W-1:SAMPLE_BITS-1] || ~|v[ACC_W-1:SAMPLE_BITS-1]) begin
      r = v[SAMPLE_BITS-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // Unsigned restoring division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(4i/N) in Q1.31, built once at elaboration, forced non-decreasing
  function automatic clip_rom_t clip_rom_build();
    clip_rom_t   t;
    logic [63:0] z, z2, z3, z4, e, v, prev, one;
    one  = 64'd1 << 31;
    prev = 64'd0;
    for (int i = 0; i <= CLIP_TABLE_SIZE; i++) begin
      z  = ((64'(i) << 34) >> CLIP_LOG) >> 8;
      z2 = (z * z) >> 31;
      z3 = (z2 * z) >> 31;
      z4 = (z3 * z) >> 31;
      e  = one - z + (z2 >> 1) - udiv64(z3, 64'd6) + udiv64(z4, 64'd24);
      for (int k = 0; k < 8; k++) begin
        e = (e * e) >> 31;
      end
      v = udiv64((one - e) << 31, one + e);
      if (v < prev) begin
        v = prev;
      end
      t[i] = v[31:0];
      prev = v;
    end
    return t;
  endfunction

endpackage

### src/ffd_if.sv
// Input and output word channels of the filtered feedback delay.
interface ffd_in_if;
  import ffd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          bypass;
  modport source(output valid, sample_in, bypass, input ready);
  modport sink(input valid, sample_in, bypass, output ready);
endinterface

interface ffd_out_if;
  import ffd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  modport source(output valid, sample_out, input ready);
  modport sink(input valid, sample_out, output ready);
endinterface

### src/ffd_regs.sv
// APB configuration registers of the filtered feedback delay.
module ffd_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ffd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output ffd_pkg::cfg_t         cfg
);
  import ffd_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // register writes; unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_length   <= RST_DELAY;
      cfg.feedback_gain  <= RST_FB;
      cfg.wet_mix        <= RST_MIX;
      cfg.lowpass_pole   <= RST_LP;
      cfg.highpass_pole  <= RST_HP;
      cfg.resonance_gain <= RST_RGAIN;
      cfg.resonance_on   <= RST_RES_ON;
    end else if (wr) begin
      unique case (idx)
        REG_DELAY:  cfg.delay_length   <= pwdata[16:0];
        REG_FB:     cfg.feedback_gain  <= pwdata[15:0];
        REG_MIX:    cfg.wet_mix        <= pwdata[16:0];
        REG_LP:     cfg.lowpass_pole   <= pwdata[15:0];
        REG_HP:     cfg.highpass_pole  <= pwdata[15:0];
        REG_RGAIN:  cfg.resonance_gain <= pwdata[16:0];
        REG_RES_ON: cfg.resonance_on   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      REG_DELAY:  prdata = {15'd0, cfg.delay_length};
      REG_FB:     prdata = {16'd0, cfg.feedback_gain};
      REG_MIX:    prdata = {15'd0, cfg.wet_mix};
      REG_LP:     prdata = {16'd0, cfg.lowpass_pole};
      REG_HP:     prdata = {16'd0, cfg.highpass_pole};
      REG_RGAIN:  prdata = {15'd0, cfg.resonance_gain};
      REG_RES_ON: prdata = {31'd0, cfg.resonance_on};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

### src/ffd_ctrl.sv
// Sequencer of the filtered feedback delay: steps the shared multiplier datapath.
module ffd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_bypass,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          res_on,
  output ffd_pkg::cmd_t cmd
);
  import ffd_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_S1   = 5'd1;
  localparam logic [4:0] ST_S2   = 5'd2;
  localparam logic [4:0] ST_S3   = 5'd3;
  localparam logic [4:0] ST_S4   = 5'd4;
  localparam logic [4:0] ST_S5   = 5'd5;
  localparam logic [4:0] ST_S6   = 5'd6;
  localparam logic [4:0] ST_S7   = 5'd7;
  localparam logic [4:0] ST_S8   = 5'd8;
  localparam logic [4:0] ST_S9   = 5'd9;
  localparam logic [4:0] ST_R1   = 5'd10;
  localparam logic [4:0] ST_R2   = 5'd11;
  localparam logic [4:0] ST_R3   = 5'd12;
  localparam logic [4:0] ST_R4   = 5'd13;
  localparam logic [4:0] ST_R5   = 5'd14;
  localparam logic [4:0] ST_R6   = 5'd15;
  localparam logic [4:0] ST_R7   = 5'd16;
  localparam logic [4:0] ST_R8   = 5'd17;
  localparam logic [4:0] ST_O1   = 5'd18;
  localparam logic [4:0] ST_O2   = 5'd19;
  localparam logic [4:0] ST_O3   = 5'd20;
  localparam logic [4:0] ST_O4   = 5'd21;
  localparam logic [4:0] ST_PUT  = 5'd22;

  logic [4:0] state, state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = ~out_valid | out_ready;

  // step table
  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid & ~out_ready;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = in_bypass ? ST_PUT : ST_S1;
        end
      end
      ST_S1: begin
        cmd.mul = MUL_A_LP;   state_next = ST_S2;
      end
      ST_S2: begin
        cmd.mul = MUL_NA_D;   cmd.acc = ACC_LD_POLE; state_next = ST_S3;
      end
      ST_S3: begin
        cmd.mul = MUL_B_HP;   cmd.acc = ACC_ADD;     state_next = ST_S4;
      end
      ST_S4: begin
        cmd.op  = OP_LP;      cmd.acc = ACC_LD_POLE; state_next = ST_S5;
      end
      ST_S5: begin
        cmd.mul = MUL_NB_LP;  state_next = ST_S6;
      end
      ST_S6: begin
        cmd.acc = ACC_ADD;    state_next = ST_S7;
      end
      ST_S7: begin
        cmd.op  = OP_HP;      state_next = ST_S8;
      end
      ST_S8: begin
        cmd.op  = OP_FSUB;    state_next = res_on ? ST_R1 : ST_S9;
      end
      ST_S9: begin
        cmd.op  = OP_FSAT;    state_next = ST_O1;
      end
      ST_R1: begin
        cmd.mul = MUL_F_RG;   state_next = ST_R2;
      end
      ST_R2: begin
        cmd.acc = ACC_LD_CLIP; state_next = ST_R3;
      end
      ST_R3: begin
        cmd.op  = OP_MAG;     state_next = ST_R4;
      end
      ST_R4: begin
        cmd.op  = OP_ROM;     state_next = ST_R5;
      end
      ST_R5: begin
        cmd.op  = OP_DIFF;    state_next = ST_R6;
      end
      ST_R6: begin
        cmd.mul = MUL_DIFF_FR; state_next = ST_R7;
      end
      ST_R7: begin
        cmd.op  = OP_R;       state_next = ST_R8;
      end
      ST_R8: begin
        cmd.op  = OP_FCLIP;   state_next = ST_O1;
      end
      ST_O1: begin
        cmd.mul = MUL_F_FG;   state_next = ST_O2;
      end
      ST_O2: begin
        cmd.mul = MUL_F_M;    cmd.acc = ACC_LD_X;    state_next = ST_O3;
      end
      ST_O3: begin
        cmd.mul = MUL_X_NM;   cmd.acc = ACC_LD_OUT;
        cmd.op  = OP_WR;      state_next = ST_O4;
      end
      ST_O4: begin
        cmd.acc = ACC_ADD;    state_next = ST_PUT;
      end
      ST_PUT: begin
        if (slot_free) begin
          cmd.op         = OP_OUT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### src/ffd_dp.sv
// Datapath of the filtered feedback delay: delay store, filters, shared multiplier, clip table.
module ffd_dp #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ffd_pkg::cfg_t                          cfg,
  input  ffd_pkg::cmd_t                          cmd,
  input  logic signed [ffd_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   in_bypass,
  output logic signed [ffd_pkg::SAMPLE_BITS-1:0] out_sample
);
  import ffd_pkg::*;

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CW = ((AW > 17) ? AW : 17) + 1;
  localparam acc_t POLE_HALF = acc_t'(1) <<< 15;
  localparam acc_t CLIP_HALF = acc_t'(1) <<< 13;
  localparam acc_t OUT_HALF  = acc_t'(1) <<< (OUT_K - 1);
  localparam clip_rom_t CLIP_ROM = clip_rom_build();

  // delay store and pointer
  logic [SAMPLE_BITS-1:0] store [DELAY_DEPTH];
  logic [AW-1:0]          wp, dl, rp;
  logic                   wrapped, d_ok;
  logic [SAMPLE_BITS-1:0] rdata;

  // item and filter state
  logic signed [SAMPLE_BITS-1:0] xin;
  logic                          byp;
  logic signed [31:0]            x, d_val, lp, hp;
  logic signed [MA_W-1:0]        f;
  acc_t                          acc, v;

  // clip path
  logic [MAG_W-1:0]       mag;
  logic                   neg;
  logic [MAG_W-CLIP_SHIFT-1:0] idx;
  logic [CLIP_AW-1:0]     a0, a1;
  logic [31:0]            rom0, rom1, diff, r;
  logic [FR_W-1:0]        fr;

  // multiplier
  logic signed [MA_W-1:0]   opa;
  logic signed [MB_W-1:0]   opb;
  logic signed [PROD_W-1:0] prod;
  logic [16:0]              na, nb, m, nm;

  // read pointer, delay clamped to depth minus one
  always_comb begin
    if (CW'(cfg.delay_length) > CW'(DELAY_DEPTH - 1)) begin
      dl = AW'(DELAY_DEPTH - 1);
    end else begin
      dl = AW'(cfg.delay_length);
    end
    if (wp >= dl) begin
      rp = wp - dl;
    end else begin
      rp = AW'(CW'(wp) + CW'(DELAY_DEPTH) - CW'(dl));
    end
  end

  assign x     = $signed({xin, {SHIFT{1'b0}}});
  assign d_val = d_ok ? $signed({rdata, {SHIFT{1'b0}}}) : 32'sd0;
  assign na    = 17'h10000 - {1'b0, cfg.lowpass_pole};
  assign nb    = 17'h10000 - {1'b0, cfg.highpass_pole};
  assign m     = cfg.wet_mix[16] ? 17'h10000 : cfg.wet_mix;
  assign nm    = 17'h10000 - m;
  assign v     = acc >>> 14;
  assign idx   = mag[MAG_W-1:CLIP_SHIFT];
  assign fr    = {mag[CLIP_SHIFT-1:0], {FR_PAD{1'b0}}};

  // table addresses, pinned to the last entry past the end
  always_comb begin
    if (idx >= (MAG_W-CLIP_SHIFT)'(CLIP_TABLE_SIZE)) begin
      a0 = CLIP_AW'(CLIP_TABLE_SIZE);
      a1 = CLIP_AW'(CLIP_TABLE_SIZE);
    end else begin
      a0 = CLIP_AW'(idx);
      a1 = CLIP_AW'(idx) + CLIP_AW'(1);
    end
  end

  // operand select
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd.mul)
      MUL_NONE:    begin opa = '0; opb = '0; end
      MUL_A_LP:    begin opa = MA_W'(lp);    opb = MB_W'({1'b0, cfg.lowpass_pole}); end
      MUL_NA_D:    begin opa = MA_W'(d_val); opb = MB_W'({1'b0, na}); end
      MUL_B_HP:    begin opa = MA_W'(hp);    opb = MB_W'({1'b0, cfg.highpass_pole}); end
      MUL_NB_LP:   begin opa = MA_W'(lp);    opb = MB_W'({1'b0, nb}); end
      MUL_F_RG:    begin opa = f;            opb = MB_W'({1'b0, cfg.resonance_gain}); end
      MUL_DIFF_FR: begin opa = $signed({1'b0, diff}); opb = $signed({1'b0, fr}); end
      MUL_F_FG:    begin opa = f;            opb = MB_W'({1'b0, cfg.feedback_gain}); end
      MUL_F_M:     begin opa = f;            opb = MB_W'({1'b0, m}); end
      MUL_X_NM:    begin opa = MA_W'(x);     opb = MB_W'({1'b0, nm}); end
      default:     begin opa = '0; opb = '0; end
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  // accumulator; rounding offsets preload so a shift finishes the rounding
  always_ff @(posedge clk) begin
    unique case (cmd.acc)
      ACC_HOLD:    acc <= acc;
      ACC_ADD:     acc <= acc + acc_t'(prod);
      ACC_LD_POLE: acc <= acc_t'(prod) + POLE_HALF;
      ACC_LD_CLIP: acc <= acc_t'(prod) + CLIP_HALF;
      ACC_LD_X:    acc <= acc_t'(prod) + ((acc_t'(x) <<< 16) | OUT_HALF);
      ACC_LD_OUT:  acc <= acc_t'(prod) + OUT_HALF;
      default:     acc <= acc;
    endcase
  end

  // delay store read at accept, write of the feedback word
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rdata <= store[rp];
      d_ok  <= wrapped | (rp < wp);
      xin   <= in_sample;
      byp   <= in_bypass;
    end
    if (cmd.op == OP_WR) begin
      store[wp] <= sat_sample(acc >>> OUT_K);
    end
  end

  // filter state and pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
      lp      <= '0;
      hp      <= '0;
    end else begin
      if (cmd.op == OP_LP) begin
        lp <= sat32(acc >>> 16);
      end
      if (cmd.op == OP_HP) begin
        hp <= sat32(acc >>> 16);
      end
      if (cmd.op == OP_WR) begin
        if (CW'(wp) + CW'(1) >= CW'(DELAY_DEPTH)) begin
          wp      <= '0;
          wrapped <= 1'b1;
        end else begin
          wp <= wp + AW'(1);
        end
      end
    end
  end

  // loop value and clip steps
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_FSUB:  f <= MA_W'(lp) - MA_W'(hp);
      OP_FSAT:  f <= MA_W'(sat32(acc_t'(f)));
      OP_MAG: begin
        mag <= MAG_W'(v[ACC_W-1] ? -v : v);
        neg <= v[ACC_W-1];
      end
      OP_ROM: begin
        rom0 <= CLIP_ROM[a0];
        rom1 <= CLIP_ROM[a1];
      end
      OP_DIFF:  diff <= rom1 - rom0;
      OP_R:     r <= rom0 + 32'(prod >>> FR_W);
      OP_FCLIP: f <= neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
      OP_OUT:   out_sample <= byp ? xin : sat_sample(acc >>> OUT_K);
      default: ;
    endcase
  end

endmodule

### src/filtered_feedback_delay_core.sv
// Top level of the filtered feedback delay: channels, register port, sequencer and datapath.
// One word in, one word out. A normal word passes through the lowpass and highpass
// filter steps, then the resonance boost and soft clip steps when they are on, then the
// feedback and mix steps, to a loaded result; a bypass word goes straight to the output
// register. The block takes no new word until its result sits in the output register,
// and is ready again in that same cycle; a result waits while an earlier word is still
// held there by the receiver. The single shared multiplier does every product in turn
// (two per filter, the boost, the clip interpolation and three for feedback and mix).
// The delay store reads as zero wherever it has not been written since reset, so no
// clearing pass is needed. Delay lengths above DELAY_DEPTH-1 act as DELAY_DEPTH-1.
module filtered_feedback_delay_core #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                       clk,
  input  logic                       rst,
  ffd_in_if.sink                     in_ch,
  ffd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ffd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ffd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  ffd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_bypass (in_ch.bypass),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_on    (cfg.resonance_on),
    .cmd       (cmd)
  );

  ffd_dp #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .in_sample  (in_ch.sample_in),
    .in_bypass  (in_ch.bypass),
    .out_sample (out_ch.sample_out)
  );

endmodule
